// ===== src/bpd_pkg.sv =====
// Shared types and codes for the bounded positional deque.
`timescale 1ns / 1ps
package bpd_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  localparam logic [OP_W-1:0] OP_ADD_FRONT    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_BACK     = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AFTER = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR        = 3'd6;
  localparam logic [OP_W-1:0] OP_DUMP         = 3'd7;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_ELEMENT = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic                    is_add;
    logic                    uses_pos;
    logic                    pos_zero;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } bpd_job_t;

endpackage

// ===== src/bpd_ifs.sv =====
// Command and response channel interfaces of the deque.
`timescale 1ns / 1ps
interface bpd_cmd_if import bpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source(output valid, operation, position, value, input ready);
  modport sink(input valid, operation, position, value, output ready);
endinterface

interface bpd_rsp_if import bpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] element;
  logic                    last;

  modport source(output valid, status, element, last, input ready);
  modport sink(input valid, status, element, last, output ready);
endinterface

// ===== src/bounded_positional_deque_core.sv =====
// A status word passes through the intake queue, then into the response register once execution takes it.
// One command per cycle while responses are taken; a dump holds the execution side while it sends
// every stored value from the row head, one element word per cycle while responses are taken.
// Intake keeps taking words into its two-entry queue while execution is busy.
// Reset clears occupancy, the queue and the response valid flag; stored values are not cleared.
`timescale 1ns / 1ps
module bounded_positional_deque_core import bpd_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic       clk,
  input logic       rst,
  bpd_cmd_if.sink   cmd,
  bpd_rsp_if.source rsp
);

  logic     job_valid;
  logic     job_ready;
  bpd_job_t job;

  bpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  bpd_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .rsp       (rsp)
  );

endmodule

// ===== src/bpd_front.sv =====
// Command intake: decodes each word and holds it in a short queue.
`timescale 1ns / 1ps
module bpd_front import bpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bpd_cmd_if.sink  cmd,
  output logic     job_valid,
  output bpd_job_t job,
  input  logic     job_ready
);

  bpd_job_t          slots [QUEUE_DEPTH];
  bpd_job_t          decoded;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;
  logic              pop;

  always_comb begin
    decoded.op       = cmd.operation;
    decoded.is_add   = cmd.operation inside {OP_ADD_FRONT, OP_ADD_BACK, OP_INSERT_AFTER};
    decoded.uses_pos = cmd.operation inside {OP_INSERT_AFTER, OP_REMOVE_AT};
    decoded.pos_zero = (cmd.position == '0);
    decoded.position = cmd.position;
    decoded.value    = cmd.value;
  end

  assign cmd.ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign job_valid = (fill != '0);
  assign job       = slots[rd_ptr];
  assign push      = cmd.valid && cmd.ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

endmodule

// ===== src/bpd_back.sv =====
// Execution: register row of values, dump sequencer and response register.
`timescale 1ns / 1ps
module bpd_back import bpd_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  bpd_job_t   job,
  output logic       job_ready,
  bpd_rsp_if.source  rsp
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int CW = (POS_W > IW) ? POS_W : IW;
  localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  localparam logic [1:0] SH_HOLD   = 2'd0;
  localparam logic [1:0] SH_PLACE  = 2'd1;
  localparam logic [1:0] SH_TAKE   = 2'd2;
  localparam logic [1:0] SH_ROTATE = 2'd3;

  logic                    state;
  logic                    state_next;
  logic [IW-1:0]           occ;
  logic [IW-1:0]           occ_next;
  logic [IW-1:0]           cnt;
  logic [IW-1:0]           cnt_next;
  logic signed [VAL_W-1:0] row [CAPACITY];
  logic [1:0]              shift_mode;
  logic [IW-1:0]           idx;
  logic [IW-1:0]           rot_end;
  logic [IW-1:0]           pos_idx;
  logic                    pos_bad;
  logic                    full;
  logic                    empty;
  logic                    out_free;
  logic                    load_out;
  logic [ST_W-1:0]         st_next;
  logic signed [VAL_W-1:0] el_next;
  logic                    last_next;

  assign full     = (occ == CAP_I);
  assign empty    = (occ == '0);
  assign pos_bad  = job.pos_zero || (CW'(job.position) > CW'(occ));
  assign pos_idx  = IW'(job.position);
  assign rot_end  = occ - 1'b1;
  assign out_free = !rsp.valid || rsp.ready;
  assign job_ready = (state == S_IDLE) && out_free;

  always_comb begin
    state_next = state;
    occ_next   = occ;
    cnt_next   = cnt;
    shift_mode = SH_HOLD;
    idx        = '0;
    load_out   = 1'b0;
    st_next    = ST_OK;
    el_next    = '0;
    last_next  = 1'b1;
    case (state)
      S_IDLE: begin
        if (job_valid && out_free) begin
          load_out = 1'b1;
          if (job.uses_pos && pos_bad) begin
            st_next = ST_INVALID;
          end else if (job.is_add && full) begin
            st_next = ST_FULL;
          end else begin
            case (job.op)
              OP_ADD_FRONT, OP_ADD_BACK, OP_INSERT_AFTER: begin
                shift_mode = SH_PLACE;
                occ_next   = occ + 1'b1;
                if (job.op == OP_ADD_BACK) begin
                  idx = occ;
                end else if (job.op == OP_INSERT_AFTER) begin
                  idx = pos_idx;
                end
              end
              OP_REMOVE_AT: begin
                shift_mode = SH_TAKE;
                idx        = pos_idx - 1'b1;
                occ_next   = occ - 1'b1;
              end
              OP_REMOVE_FRONT: begin
                if (empty) begin
                  st_next = ST_EMPTY;
                end else begin
                  shift_mode = SH_TAKE;
                  occ_next   = occ - 1'b1;
                end
              end
              OP_REMOVE_BACK: begin
                if (empty) begin
                  st_next = ST_EMPTY;
                end else begin
                  occ_next = occ - 1'b1;
                end
              end
              OP_CLEAR: begin
                if (empty) begin
                  st_next = ST_EMPTY;
                end else begin
                  occ_next = '0;
                end
              end
              default: begin
                if (empty) begin
                  st_next = ST_EMPTY;
                end else begin
                  load_out   = 1'b0;
                  cnt_next   = occ;
                  state_next = S_DUMP;
                end
              end
            endcase
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load_out   = 1'b1;
          st_next    = ST_ELEMENT;
          el_next    = row[0];
          last_next  = (cnt == IW'(1));
          shift_mode = SH_ROTATE;
          cnt_next   = cnt - 1'b1;
          if (cnt == IW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam logic [IW-1:0] K = IW'(k);
    logic signed [VAL_W-1:0] from_prev;
    logic signed [VAL_W-1:0] from_next;

    if (k == 0) begin : g_first
      assign from_prev = row[0];
    end else begin : g_prev
      assign from_prev = row[k-1];
    end
    if (k == CAPACITY - 1) begin : g_final
      assign from_next = row[k];
    end else begin : g_next
      assign from_next = row[k+1];
    end

    always_ff @(posedge clk) begin
      case (shift_mode)
        SH_PLACE: begin
          if (K == idx) begin
            row[k] <= job.value;
          end else if (K > idx) begin
            row[k] <= from_prev;
          end
        end
        SH_TAKE: begin
          if (K >= idx) begin
            row[k] <= from_next;
          end
        end
        SH_ROTATE: begin
          if (K == rot_end) begin
            row[k] <= row[0];
          end else if (K < rot_end) begin
            row[k] <= from_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      cnt   <= cnt_next;
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status  <= st_next;
      rsp.element <= el_next;
      rsp.last    <= last_next;
    end
  end

endmodule

// ===== src/bpd_checker.sv =====
// Port-level checks for the deque, bound to the top level.
`timescale 1ns / 1ps
module bpd_checker import bpd_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cmd_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic [ST_W-1:0]         rsp_status,
  input logic signed [VAL_W-1:0] rsp_element,
  input logic                    rsp_last
);

  a_status_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_ELEMENT) |-> (rsp_element == '0) && rsp_last)
    else $error("status word carries data or lacks last");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status <= ST_ELEMENT))
    else $error("undefined status code");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_element) && $stable(rsp_last))
    else $error("stalled response word changed");

  a_reset_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_reset_cmd: assert property (@(posedge clk) rst |=> cmd_ready)
    else $error("command side not ready after reset");

endmodule

bind bounded_positional_deque_core bpd_checker u_bpd_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_element (rsp.element),
  .rsp_last    (rsp.last)
);
